### design/epsilon_closure_engine_macros.svh
// assertion helpers for the epsilon closure engine
// each one samples on i_clk and is switched off while i_rst_n is low
`ifndef EPSILON_CLOSURE_ENGINE_MACROS_SVH
`define EPSILON_CLOSURE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must never hold
`define ECE_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ECE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ECE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ECE_ASSERT_NEVER(label, expr, msg)
`define ECE_ASSERT_IMPLY(label, ante, cons, msg)
`define ECE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/ece_pkg.sv
`timescale 1ns / 1ps

package ece_pkg;

    // table size default
    localparam int NUM_STATES_DEF = 16;

    // fixed field widths
    localparam int IDX_IN_W = 4;
    localparam int TGT_W    = 16;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 5;
    localparam int ACT_W    = 5;

    // packed stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // active state count after reset
    localparam logic [ACT_W-1:0] ACTIVE_RST = 5'd16;

    // request kinds carried in tuser
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_e;

endpackage

### design/ece_pick_unit.sv
`timescale 1ns / 1ps

// lowest-set-bit picker shared by every expansion step
module ece_pick_unit
    import ece_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    localparam int IDX_W     = $clog2(NUM_STATES)
) (
    input  logic [NUM_STATES-1:0] i_pending,
    output logic [NUM_STATES-1:0] o_onehot,
    output logic [IDX_W-1:0]      o_index,
    output logic                  o_any
);

    // isolate the lowest pending bit with one add
    assign o_onehot = i_pending & (~i_pending + NUM_STATES'(1));
    assign o_any    = |i_pending;

    // encode the one-hot position
    always_comb begin
        o_index = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (o_onehot[i]) begin
                o_index = o_index | IDX_W'(i);
            end
        end
    end

endmodule

### design/epsilon_closure_engine.sv
`timescale 1ns / 1ps

// Epsilon closure engine.
// Input stream (s_axis): tuser selects the request. A write word (tuser 0) stores
// edge_targets as the epsilon row of state_index; it gives no result. A query word
// (tuser 1) names a start state; the engine then expands one pending state per
// cycle through a single picker and a one-port row memory. The closure holds no
// state for an inactive start and at most 16 for the default table. s_axis_tready
// is low from the query until the result is loaded into the output register; the
// result word turns valid at the same edge at which the engine returns to idle and
// can take the next word.
// Output stream (m_axis): one word per query, closure_mask and member_count. The
// result sits in an output register, so a new word is taken while it waits; a
// finished query that finds the register still full holds until the receiver
// takes the earlier word.
// Configuration: i_cfg_we writes active_states (reset 16); write it only when idle.
// Reset (synchronous, i_rst_n low) clears every row to no transitions at once by
// per-row valid bits, empties the output register and returns to idle.
module epsilon_closure_engine
    import ece_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [ACT_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [3:0] state_index, [19:4] edge_targets, [23:20] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  logic                 s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] closure_mask, [20:16] member_count, [23:21] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    `include "epsilon_closure_engine_macros.svh"

    localparam int IDX_W  = $clog2(NUM_STATES);
    localparam int IDXX_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
    localparam int EXT_W  = (NUM_STATES > TGT_W) ? NUM_STATES : TGT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state_e;

    t_state_e               r_state;
    logic [ACT_W-1:0]       r_active;
    logic [NUM_STATES-1:0]  r_row_valid;
    logic [NUM_STATES-1:0]  r_included;
    logic [NUM_STATES-1:0]  r_expanded;
    logic [CNT_W-1:0]       r_count;
    logic                   r_rd_pend;
    logic                   r_rd_vld;
    logic [NUM_STATES-1:0]  r_rd_data;
    logic                   r_out_valid;
    logic [MASK_W-1:0]      r_out_mask;
    logic [CNT_W-1:0]       r_out_count;

    logic [NUM_STATES-1:0]  row_mem [NUM_STATES];

    logic [IDX_IN_W-1:0]    in_idx;
    logic [TGT_W-1:0]       in_targets;
    logic [IDXX_W-1:0]      in_idx_ext;
    logic [IDX_W-1:0]       wr_addr;
    logic [NUM_STATES-1:0]  wr_row;
    logic [EXT_W-1:0]       targets_ext;
    logic                   in_accept;
    logic                   wr_en;
    logic                   idx_in_table;
    logic [NUM_STATES-1:0]  act_mask;
    logic [NUM_STATES-1:0]  start_mask;
    logic [NUM_STATES-1:0]  n_included;
    logic [NUM_STATES-1:0]  pending;
    logic [NUM_STATES-1:0]  pick_onehot;
    logic [IDX_W-1:0]       pick_index;
    logic                   pick_any;
    logic                   rd_en;
    logic                   out_free;
    logic                   out_load;
    logic [EXT_W-1:0]       closure_ext;

    // unpack the request word
    assign in_idx      = s_axis_tdata[IDX_IN_W-1:0];
    assign in_targets  = s_axis_tdata[IDX_IN_W +: TGT_W];
    assign in_idx_ext  = IDXX_W'(in_idx);
    assign wr_addr     = in_idx_ext[IDX_W-1:0];
    assign targets_ext = EXT_W'(in_targets);
    assign wr_row      = targets_ext[NUM_STATES-1:0];
    assign idx_in_table = (int'(in_idx) < NUM_STATES);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign wr_en         = in_accept && (t_req_e'(s_axis_tuser) == REQ_WRITE) && idx_in_table;

    // active states and the start state as masks
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            act_mask[i]   = (i < int'(r_active));
            start_mask[i] = (int'(in_idx) == i);
        end
    end

    // fold in the row read last cycle, a row never written reads as no transitions
    assign n_included = r_included |
                        ((r_rd_pend && r_rd_vld) ? (r_rd_data & act_mask) : '0);
    assign pending    = n_included & ~r_expanded;

    ece_pick_unit #(
        .NUM_STATES (NUM_STATES)
    ) u_pick (
        .i_pending (pending),
        .o_onehot  (pick_onehot),
        .o_index   (pick_index),
        .o_any     (pick_any)
    );

    assign rd_en    = (r_state == S_RUN) && pick_any;
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (((r_state == S_RUN) && !pick_any) || (r_state == S_HOLD)) && out_free;

    // row memory, one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_data <= row_mem[pick_index];
        end
    end

    // sequencer, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RST;
            r_row_valid <= '0;
            r_included  <= '0;
            r_expanded  <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            // output register load or drain
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_mask  <= closure_ext[MASK_W-1:0];
                r_out_count <= r_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (t_req_e'(s_axis_tuser) == REQ_QUERY)) begin
                        r_included <= start_mask & act_mask;
                        r_expanded <= '0;
                        r_count    <= '0;
                        r_rd_pend  <= 1'b0;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_included <= n_included;
                    if (pick_any) begin
                        r_expanded <= r_expanded | pick_onehot;
                        r_count    <= r_count + CNT_W'(1);
                        r_rd_pend  <= 1'b1;
                        r_rd_vld   <= r_row_valid[pick_index];
                    end else begin
                        r_rd_pend <= 1'b0;
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // closure word for the output register
    assign closure_ext = EXT_W'(n_included);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - MASK_W - CNT_W)'(0), r_out_count, r_out_mask};

    // checks
    `ECE_ASSERT_NEVER(a_expanded_in_closure, |(r_expanded & ~r_included),
        "expanded state missing from closure")
    `ECE_ASSERT_IMPLY(a_count_matches, r_state == S_RUN,
        $countones(r_expanded) == int'(r_count), "member count out of step")
    `ECE_ASSERT_NEVER(a_hold_out_full, (r_state == S_HOLD) && !r_out_valid,
        "holding a result with the output register empty")

endmodule
